@@ rtl/core/roqfs_pkg.sv @@
// Shared types and constants for the resting order queue fill simulator.
package roqfs_pkg;

  localparam logic [1:0] OP_PLACE  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TRADE  = 2'd2;

  localparam logic CFG_TAKER = 1'b0;
  localparam logic CFG_MAKER = 1'b1;

  localparam logic [33:0] POS_MAX = {1'b0, {33{1'b1}}};
  localparam logic [33:0] POS_MIN = {1'b1, {33{1'b0}}};
  localparam logic [62:0] VOL_MAX = {63{1'b1}};
  localparam logic [63:0] CASH_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] CASH_MIN = {1'b1, {63{1'b0}}};

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture input request, run decision
    logic fill_mul;   // start notional multiply for pending fill
    logic fee_lo;     // fee partial product, low half
    logic fee_hi;     // fee partial product, high half, combine
    logic commit;     // update accounts and load output register
    logic last;       // last flag for the committed fill
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic fill_pend;  // a fill is queued
    logic more;       // another fill may follow (sell side after buy)
  } dp_sts_t;

endpackage

@@ rtl/core/roqfs_datapath.sv @@
// Datapath: order state, fill selection, multiplies and saturating accounts.
module roqfs_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  roqfs_pkg::dp_cmd_t    cmd,
  output roqfs_pkg::dp_sts_t    sts,
  input  logic                  cfg_valid,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [1:0]            in_op,
  input  logic                  in_side,
  input  logic [23:0]           in_price,
  input  logic [31:0]           in_quantity,
  input  logic [31:0]           in_order_id,
  input  logic [31:0]           in_queue_ahead,
  input  logic [23:0]           in_opposite_best,
  input  logic                  out_load,
  output logic                  out_fill_side,
  output logic [23:0]           out_fill_price,
  output logic [31:0]           out_fill_quantity,
  output logic signed [63:0]    out_fee,
  output logic                  out_taker,
  output logic signed [33:0]    out_position_after,
  output logic signed [63:0]    out_cash_after,
  output logic [62:0]           out_volume_after,
  output logic                  out_last
);
  import roqfs_pkg::*;

  logic signed [31:0] taker_r, maker_r;
  logic        buy_act_r, sell_act_r;
  logic [31:0] buy_id_r, sell_id_r, buy_rem_r, sell_rem_r, buy_q_r, sell_q_r;
  logic [23:0] buy_px_r, sell_px_r;
  logic signed [63:0] cash_r;
  logic signed [33:0] pos_r;
  logic [62:0] vol_r;

  // sell-side fill held back while a buy fill of the same trade commits
  logic [23:0] t_px_r;
  logic [31:0] t_qty_r;
  logic        more_r;

  // pending fill
  logic        pend_r, f_side_r, f_taker_r;
  logic [23:0] f_px_r;
  logic [31:0] f_qty_r;
  logic [55:0] notional_r;
  logic [31:0] mag_r;
  logic        neg_r;
  logic [63:0] plo_r;
  logic [63:0] fee_r;

  // match evaluation for one side against a trade
  typedef struct packed {
    logic        fill;
    logic [31:0] qty;
    logic        act;
    logic [31:0] rem;
    logic [31:0] q;
  } match_t;

  function automatic match_t do_match(input logic act, input logic [23:0] opx,
                                      input logic [31:0] rem, input logic [31:0] q,
                                      input logic [23:0] tpx, input logic [31:0] tqty,
                                      input logic thru, input logic atpx);
    match_t m;
    logic [31:0] eat, left, f;
    m.fill = 1'b0; m.qty = rem; m.act = act; m.rem = rem; m.q = q;
    eat = (q < tqty) ? q : tqty;
    left = tqty - eat;
    f = (rem < left) ? rem : left;
    if (act) begin
      if (thru) begin
        m.fill = 1'b1; m.qty = rem; m.rem = '0; m.act = 1'b0;
      end else if (tpx == opx && atpx) begin
        m.q = q - eat;
        if (m.q == '0 && left != '0) begin
          m.fill = (f != '0);
          m.qty = f;
          m.rem = rem - f;
          if (m.rem == '0) m.act = 1'b0;
        end
      end
    end
    return m;
  endfunction

  match_t bm, sm;
  assign bm = do_match(buy_act_r, buy_px_r, buy_rem_r, buy_q_r, in_price, in_quantity,
                       in_price < buy_px_r, in_side);
  assign sm = do_match(sell_act_r, sell_px_r, sell_rem_r, sell_q_r, in_price, in_quantity,
                       in_price > sell_px_r, !in_side);

  assign sts.fill_pend = pend_r;
  assign sts.more = more_r;

  // accounting combinational
  logic [62:0] vol_sum;
  logic signed [64:0] c1w, c2w;
  logic signed [63:0] c1;
  logic signed [34:0] pw;
  logic [63:0] fee_v;
  logic [64:0] whole;

  always_comb begin
    whole = {1'b0, fee_r} + {33'd0, plo_r[63:32]};
    fee_v = neg_r ? (~(whole[63:0] + {63'd0, plo_r[31:0] != '0}) + 64'd1) : whole[63:0];
    if (f_side_r) c1w = {cash_r[63], cash_r} + {9'd0, notional_r};
    else          c1w = {cash_r[63], cash_r} - {9'd0, notional_r};
    if (c1w[64] != c1w[63]) c1 = c1w[64] ? CASH_MIN : CASH_MAX;
    else c1 = c1w[63:0];
    c2w = {c1[63], c1} + {fee_v[63], fee_v};
    if (f_side_r) pw = {pos_r[33], pos_r} - {3'd0, f_qty_r};
    else          pw = {pos_r[33], pos_r} + {3'd0, f_qty_r};
    vol_sum = (vol_r > VOL_MAX - {7'd0, notional_r}) ? VOL_MAX : vol_r + {7'd0, notional_r};
  end

  logic signed [63:0] c2;
  logic signed [33:0] pn;
  assign c2 = (c2w[64] != c2w[63]) ? (c2w[64] ? CASH_MIN : CASH_MAX) : c2w[63:0];
  assign pn = (pw[34] != pw[33]) ? (pw[34] ? POS_MIN : POS_MAX) : pw[33:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taker_r <= '0; maker_r <= '0;
      buy_act_r <= 1'b0; sell_act_r <= 1'b0;
      buy_id_r <= '0; sell_id_r <= '0; buy_rem_r <= '0; sell_rem_r <= '0;
      buy_q_r <= '0; sell_q_r <= '0; buy_px_r <= '0; sell_px_r <= '0;
      cash_r <= '0; pos_r <= '0; vol_r <= '0;
      pend_r <= 1'b0; more_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_TAKER) taker_r <= cfg_data;
        else maker_r <= cfg_data;
      end
      if (cmd.load) begin
        // a second fill only when a trade fills both sides
        more_r <= (in_op == OP_TRADE) && bm.fill && sm.fill;
        case (in_op)
          OP_PLACE: begin
            if (in_quantity != '0) begin
              if (!in_side) begin
                if (in_opposite_best != '0 && in_price >= in_opposite_best) begin
                  pend_r <= 1'b1; f_side_r <= 1'b0; f_taker_r <= 1'b1;
                  f_px_r <= in_opposite_best; f_qty_r <= in_quantity;
                end else begin
                  buy_act_r <= 1'b1; buy_id_r <= in_order_id; buy_px_r <= in_price;
                  buy_rem_r <= in_quantity; buy_q_r <= in_queue_ahead;
                end
              end else begin
                if (in_opposite_best != '0 && in_price <= in_opposite_best) begin
                  pend_r <= 1'b1; f_side_r <= 1'b1; f_taker_r <= 1'b1;
                  f_px_r <= in_opposite_best; f_qty_r <= in_quantity;
                end else begin
                  sell_act_r <= 1'b1; sell_id_r <= in_order_id; sell_px_r <= in_price;
                  sell_rem_r <= in_quantity; sell_q_r <= in_queue_ahead;
                end
              end
            end
          end
          OP_CANCEL: begin
            if (!in_side && buy_act_r && buy_id_r == in_order_id) buy_act_r <= 1'b0;
            else if (in_side && sell_act_r && sell_id_r == in_order_id) sell_act_r <= 1'b0;
          end
          OP_TRADE: begin
            // both sides resolve now; buy fill goes first, sell fill waits behind it
            buy_act_r <= bm.act; buy_rem_r <= bm.rem; buy_q_r <= bm.q;
            sell_act_r <= sm.act; sell_rem_r <= sm.rem; sell_q_r <= sm.q;
            t_px_r <= sell_px_r; t_qty_r <= sm.qty;
            if (bm.fill) begin
              pend_r <= 1'b1; f_side_r <= 1'b0; f_taker_r <= 1'b0;
              f_px_r <= buy_px_r; f_qty_r <= bm.qty;
            end else if (sm.fill) begin
              pend_r <= 1'b1; f_side_r <= 1'b1; f_taker_r <= 1'b0;
              f_px_r <= sell_px_r; f_qty_r <= sm.qty;
            end
          end
          default: ;
        endcase
      end else if (more_r && !pend_r) begin
        more_r <= 1'b0;
        pend_r <= 1'b1; f_side_r <= 1'b1; f_taker_r <= 1'b0;
        f_px_r <= t_px_r; f_qty_r <= t_qty_r;
      end
      if (cmd.commit) begin
        pend_r <= 1'b0;
        cash_r <= c2; pos_r <= pn; vol_r <= vol_sum;
      end
    end
  end

  // multiply datapath: notional, then rate magnitude by low and high halves
  always_ff @(posedge clk) begin
    if (cmd.fill_mul) begin
      notional_r <= {32'd0, f_px_r} * {24'd0, f_qty_r};
      mag_r <= f_taker_r ? (taker_r[31] ? 32'(-taker_r) : taker_r)
                         : (maker_r[31] ? 32'(-maker_r) : maker_r);
      neg_r <= f_taker_r ? taker_r[31] : maker_r[31];
    end
    if (cmd.fee_lo) plo_r <= {32'd0, notional_r[31:0]} * {32'd0, mag_r};
    if (cmd.fee_hi) fee_r <= {40'd0, notional_r[55:32]} * {32'd0, mag_r};
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fill_side <= f_side_r; out_fill_price <= f_px_r;
      out_fill_quantity <= f_qty_r; out_fee <= fee_v; out_taker <= f_taker_r;
      out_position_after <= pn; out_cash_after <= c2; out_volume_after <= vol_sum;
      out_last <= cmd.last;
    end
  end
endmodule

@@ rtl/core/roqfs_ctrl.sv @@
// Controller: sequences capture, multiplies and result delivery.
module roqfs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_load,
  input  roqfs_pkg::dp_sts_t sts,
  output roqfs_pkg::dp_cmd_t cmd
);
  import roqfs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_MUL  = 6'b000100,
    S_FLO  = 6'b001000,
    S_FHI  = 6'b010000,
    S_COM  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   can_out;

  // output register can take a new result when empty or draining
  assign can_out = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    ov_nxt = ov_r && !out_ready;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.fill_pend) state_nxt = S_MUL;
        else if (!sts.more) state_nxt = S_IDLE;
      end
      S_MUL: begin cmd.fill_mul = 1'b1; state_nxt = S_FLO; end
      S_FLO: begin cmd.fee_lo = 1'b1; state_nxt = S_FHI; end
      S_FHI: begin cmd.fee_hi = 1'b1; state_nxt = S_COM; end
      S_COM: if (can_out) begin
        cmd.commit = 1'b1; cmd.last = !sts.more; out_load = 1'b1; ov_nxt = 1'b1;
        state_nxt = sts.more ? S_EVAL : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end
endmodule

@@ rtl/core/resting_order_queue_fill_simulator.sv @@
// Top level of the resting order queue fill simulator.
//   channel | ports                          | request
//   input   | in_valid/in_ready + fields      | place, cancel or trade
//   output  | out_valid/out_ready + fields    | one fill, last marks end
//   config  | cfg_valid/cfg_ready, index,data | rate register write
// A request with no fill returns to idle after the evaluate step; each fill adds the
// notional multiply, two fee partial products and commit steps, and a second fill is
// first loaded from the held sell side while the controller waits in evaluate.
// The fee path through a 32x32 and a 24x32 multiply sets the per-fill length.
// Reset (rst_n low, synchronous) clears orders, accounts and rates.
// A stalled output holds the commit step; inputs wait while a request runs.
module resting_order_queue_fill_simulator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic                in_side,
  input  logic [23:0]         in_price,
  input  logic [31:0]         in_quantity,
  input  logic [31:0]         in_order_id,
  input  logic [31:0]         in_queue_ahead,
  input  logic [23:0]         in_opposite_best,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_fill_side,
  output logic [23:0]         out_fill_price,
  output logic [31:0]         out_fill_quantity,
  output logic signed [63:0]  out_fee,
  output logic                out_taker,
  output logic signed [33:0]  out_position_after,
  output logic signed [63:0]  out_cash_after,
  output logic [62:0]         out_volume_after,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import roqfs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    out_load;

  // rate writes always taken
  assign cfg_ready = 1'b1;

  roqfs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .out_load, .sts, .cmd
  );

  roqfs_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_valid, .cfg_index, .cfg_data,
    .in_op, .in_side, .in_price, .in_quantity, .in_order_id,
    .in_queue_ahead, .in_opposite_best,
    .out_load, .out_fill_side, .out_fill_price, .out_fill_quantity, .out_fee,
    .out_taker, .out_position_after, .out_cash_after, .out_volume_after,
    .out_last
  );
endmodule
